// ----- rtl/core/swirl_warp_coordinate_map_macros.svh -----
// assertion macros used by the checker
`ifndef SWIRL_WARP_COORDINATE_MAP_MACROS_SVH
`define SWIRL_WARP_COORDINATE_MAP_MACROS_SVH

// checked only while out of reset
`define SWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SWM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/core/swm_pkg.sv -----
package swm_pkg;

  // field widths
  localparam int DEST_W  = 12;
  localparam int OUT_W   = 23;
  localparam int PCT_W   = 15;
  localparam int FORCE_W = 32;
  localparam int DIM_W   = 13;

  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // internal datapath widths
  localparam int PN_W   = 28;  // (dim-1)*pct + 50
  localparam int CX_W   = 21;  // center, Q.8
  localparam int OFS_W  = 22;  // offset from center, signed Q.8
  localparam int SUM_W  = 44;  // squared distance
  localparam int ROOT_W = 22;  // distance
  localparam int MAG_W  = 54;  // distance * |force|
  localparam int SX_W   = 56;  // offset times inverse gain
  localparam int XY_W   = 40;  // rotator vector, Q.24
  localparam int Z_W    = 34;  // residual angle
  localparam int SUMO_W = 26;  // center plus rotated offset

  localparam int CORDIC_STAGES = 16;

  // divide by 100 through a reciprocal
  localparam logic [PN_W-1:0] RECIP_M   = 28'd171798692;
  localparam int              RECIP_SH  = 34;
  localparam logic [31:0]     INV_GAIN  = 32'd2608131496;
  localparam logic [30:0]     ANGLE_K   = 31'd1749927105;
  localparam logic [PN_W-1:0] ROUND_HALF_PCT = 28'd50;

  // register map
  typedef enum logic [2:0] {
    REG_CENTER_X_PCT = 3'd0,
    REG_CENTER_Y_PCT = 3'd1,
    REG_TWIST_FORCE  = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_e;

  // arctangent of 2^-i in binary angle units (2^32 per turn)
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // per-item data that rides along to the output
  typedef struct packed {
    logic              bypass;
    logic [DEST_W-1:0] dest_x;
    logic [DEST_W-1:0] dest_y;
    logic [CX_W-1:0]   cx;
    logic [CX_W-1:0]   cy;
  } geo_t;

  // geometry plus the gain-scaled offset vector
  typedef struct packed {
    geo_t              geo;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
  } vec_side_t;

endpackage

// ----- rtl/core/swm_isqrt.sv -----
module swm_isqrt
  import swm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SUM_W-1:0] radicand_i,
  input  vec_side_t        side_i,
  output logic             valid_o,
  output logic [ROOT_W-1:0] root_o,
  output vec_side_t        side_o
);

  logic              vld_q  [ROOT_W];
  logic [SUM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  vec_side_t         side_q [ROOT_W];

  // one root bit per stage, most significant first
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int B = ROOT_W - 1 - j;
    logic              vld_in;
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    vec_side_t         side_in;
    logic [SUM_W:0]    trial;
    logic              fits;

    if (j == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
      assign side_in = side_q[j-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({{(SUM_W+1-ROOT_W){1'b0}}, root_in} << (B + 1))
                 + ((SUM_W+1)'(1) << (2 * B));
    assign fits  = {1'b0, rem_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fits ? rem_in - trial[SUM_W-1:0] : rem_in;
        root_q[j] <= fits ? (root_in | (ROOT_W'(1) << B)) : root_in;
        side_q[j] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign side_o  = side_q[ROOT_W-1];

endmodule

// ----- rtl/core/swm_cordic.sv -----
module swm_cordic
  import swm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  geo_t                   geo_i,
  output logic                   valid_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output geo_t                   geo_o
);

  logic                   vld_q [CORDIC_STAGES];
  logic signed [XY_W-1:0] x_q   [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q   [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q   [CORDIC_STAGES];
  geo_t                   geo_q [CORDIC_STAGES];

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic                   vld_in;
    logic signed [XY_W-1:0] x_in, y_in, dx, dy;
    logic signed [Z_W-1:0]  z_in, at;
    geo_t                   geo_in;

    if (i == 0) begin : g_first
      assign vld_in = valid_i;
      assign x_in   = x_i;
      assign y_in   = y_i;
      assign z_in   = z_i;
      assign geo_in = geo_i;
    end else begin : g_next
      assign vld_in = vld_q[i-1];
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign z_in   = z_q[i-1];
      assign geo_in = geo_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;
    assign at = $signed({{(Z_W-32){1'b0}}, ATAN_TURNS[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_in[Z_W-1]) begin
          x_q[i] <= x_in - dx;
          y_q[i] <= y_in + dy;
          z_q[i] <= z_in - at;
        end else begin
          x_q[i] <= x_in + dx;
          y_q[i] <= y_in - dy;
          z_q[i] <= z_in + at;
        end
        geo_q[i] <= geo_in;
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES-1];
  assign x_o     = x_q[CORDIC_STAGES-1];
  assign y_o     = y_q[CORDIC_STAGES-1];
  assign geo_o   = geo_q[CORDIC_STAGES-1];

endmodule

// ----- rtl/core/swirl_warp_coordinate_map.sv -----
// throughput: one beat per cycle unless the output stalls; 5 setup stages, 22 square-root stages,
// 4 angle stages, 16 rotator stages and the output register
// a stalled output holds the whole pipeline, nothing is dropped
// reset (async, active low) clears all valid bits and loads register defaults
module swirl_warp_coordinate_map
  import swm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // dest_x [11:0], dest_y [23:12]
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // src_x [22:0], src_y [45:23], zeros [47:46]
);

  // configuration registers
  logic [PCT_W-1:0]   cfg_cx_pct_q, cfg_cy_pct_q;
  logic [FORCE_W-1:0] cfg_force_q;
  logic [DIM_W-1:0]   cfg_width_q, cfg_height_q;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_pct_q <= 15'd12800;
      cfg_cy_pct_q <= 15'd12800;
      cfg_force_q  <= '0;
      cfg_width_q  <= 13'd1;
      cfg_height_q <= 13'd1;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_CENTER_X_PCT: cfg_cx_pct_q <= pwdata[PCT_W-1:0];
        REG_CENTER_Y_PCT: cfg_cy_pct_q <= pwdata[PCT_W-1:0];
        REG_TWIST_FORCE:  cfg_force_q  <= pwdata;
        REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_CENTER_X_PCT: prdata = {17'b0, cfg_cx_pct_q};
      REG_CENTER_Y_PCT: prdata = {17'b0, cfg_cy_pct_q};
      REG_TWIST_FORCE:  prdata = cfg_force_q;
      REG_IMAGE_WIDTH:  prdata = {19'b0, cfg_width_q};
      REG_IMAGE_HEIGHT: prdata = {19'b0, cfg_height_q};
      default:          prdata = '0;
    endcase
  end

  // pipeline advance: output register empty or being drained
  logic en, m_valid_q;
  logic [47:0] m_data_q;

  assign en            = !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // stage 1: (dim-1)*pct + 50
  logic [DIM_W-1:0]  dim_x, dim_y;
  logic              s1_vld_q, s1_bypass_q;
  logic [DEST_W-1:0] s1_dx_q, s1_dy_q;
  logic [PN_W-1:0]   s1_pnx_q, s1_pny_q;

  assign dim_x = (cfg_width_q > MAX_DIM) ? MAX_DIM : cfg_width_q;
  assign dim_y = (cfg_height_q > MAX_DIM) ? MAX_DIM : cfg_height_q;

  // stage 2: divide by 100
  logic              s2_vld_q;
  geo_t              s2_geo_q;
  logic [SX_W-1:0]   qx, qy;

  assign qx = SX_W'(s1_pnx_q) * SX_W'(RECIP_M);
  assign qy = SX_W'(s1_pny_q) * SX_W'(RECIP_M);

  // stage 3: offset from center
  logic              s3_vld_q;
  geo_t              s3_geo_q;
  logic [OFS_W-1:0]  s3_ox_q, s3_oy_q;

  // stage 4: squares and gain scaling
  logic              s4_vld_q;
  geo_t              s4_geo_q;
  logic [SUM_W-1:0]  ox_e, oy_e;
  logic [SX_W-1:0]   ox_w, oy_w;
  logic [SUM_W-1:0]  s4_sqx_q, s4_sqy_q;
  logic [SX_W-1:0]   s4_sx_q, s4_sy_q;

  assign ox_e = {{(SUM_W-OFS_W){s3_ox_q[OFS_W-1]}}, s3_ox_q};
  assign oy_e = {{(SUM_W-OFS_W){s3_oy_q[OFS_W-1]}}, s3_oy_q};
  assign ox_w = {{(SX_W-OFS_W){s3_ox_q[OFS_W-1]}}, s3_ox_q};
  assign oy_w = {{(SX_W-OFS_W){s3_oy_q[OFS_W-1]}}, s3_oy_q};

  // stage 5: sum of squares, rounded Q.24 vector
  logic              s5_vld_q;
  vec_side_t         s5_side_q;
  logic [SUM_W-1:0]  s5_sum_q;
  logic [SX_W-1:0]   sxr, syr;

  assign sxr = s4_sx_q + SX_W'(32768);
  assign syr = s4_sy_q + SX_W'(32768);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= s_axis_tvalid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_dx_q     <= s_axis_tdata[11:0];
      s1_dy_q     <= s_axis_tdata[23:12];
      s1_bypass_q <= (cfg_force_q == '0) || (cfg_width_q == '0) || (cfg_height_q == '0);
      s1_pnx_q    <= PN_W'(dim_x - 13'd1) * PN_W'(cfg_cx_pct_q) + ROUND_HALF_PCT;
      s1_pny_q    <= PN_W'(dim_y - 13'd1) * PN_W'(cfg_cy_pct_q) + ROUND_HALF_PCT;

      s2_geo_q.bypass <= s1_bypass_q;
      s2_geo_q.dest_x <= s1_dx_q;
      s2_geo_q.dest_y <= s1_dy_q;
      s2_geo_q.cx     <= qx[RECIP_SH +: CX_W];
      s2_geo_q.cy     <= qy[RECIP_SH +: CX_W];

      s3_geo_q <= s2_geo_q;
      s3_ox_q  <= {2'b0, s2_geo_q.dest_x, 8'b0} - {1'b0, s2_geo_q.cx};
      s3_oy_q  <= {2'b0, s2_geo_q.dest_y, 8'b0} - {1'b0, s2_geo_q.cy};

      s4_geo_q <= s3_geo_q;
      s4_sqx_q <= ox_e * ox_e;
      s4_sqy_q <= oy_e * oy_e;
      s4_sx_q  <= ox_w * SX_W'(INV_GAIN);
      s4_sy_q  <= oy_w * SX_W'(INV_GAIN);

      s5_side_q.geo <= s4_geo_q;
      s5_side_q.x   <= sxr[16 +: XY_W];
      s5_side_q.y   <= syr[16 +: XY_W];
      s5_sum_q      <= s4_sqx_q + s4_sqy_q;
    end
  end

  // distance
  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  vec_side_t         sq_side;

  swm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s5_vld_q),
    .radicand_i (s5_sum_q),
    .side_i     (s5_side_q),
    .valid_o    (sq_vld),
    .root_o     (sq_root),
    .side_o     (sq_side)
  );

  // angle stage a: distance * |force|
  logic [FORCE_W-1:0] abs_force;
  logic               sa_vld_q;
  vec_side_t          sa_side_q;
  logic [MAG_W-1:0]   sa_mag_q;

  assign abs_force = cfg_force_q[FORCE_W-1] ? (~cfg_force_q + 32'd1) : cfg_force_q;

  // angle stage b: scale to binary angle, two partial products
  logic               sb_vld_q;
  vec_side_t          sb_side_q;
  logic [62:0]        sb_p1_q;
  logic [31:0]        sb_p2_q;

  // angle stage c: sum and sign
  logic               sc_vld_q;
  vec_side_t          sc_side_q;
  logic [31:0]        t_sum, sc_t_q;

  assign t_sum = sb_p2_q + {1'b0, sb_p1_q[62:32]};

  // angle stage d: half-plane fold
  logic               sd_vld_q;
  geo_t               sd_geo_q;
  logic [XY_W-1:0]    sd_x_q, sd_y_q;
  logic [Z_W-1:0]     sd_z_q;
  logic [31:0]        t_chk, t_fold;
  logic               fold;

  assign t_chk  = sc_t_q + 32'h4000_0000;
  assign fold   = t_chk[31];
  assign t_fold = fold ? (sc_t_q + 32'h8000_0000) : sc_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_vld_q <= 1'b0;
      sb_vld_q <= 1'b0;
      sc_vld_q <= 1'b0;
      sd_vld_q <= 1'b0;
    end else if (en) begin
      sa_vld_q <= sq_vld;
      sb_vld_q <= sa_vld_q;
      sc_vld_q <= sb_vld_q;
      sd_vld_q <= sc_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_side_q <= sq_side;
      sa_mag_q  <= MAG_W'(sq_root) * MAG_W'(abs_force);

      sb_side_q <= sa_side_q;
      sb_p1_q   <= 63'(sa_mag_q[31:0]) * 63'(ANGLE_K);
      sb_p2_q   <= {10'b0, sa_mag_q[MAG_W-1:32]} * {1'b0, ANGLE_K};

      sc_side_q <= sb_side_q;
      sc_t_q    <= cfg_force_q[FORCE_W-1] ? (32'd0 - t_sum) : t_sum;

      sd_geo_q  <= sc_side_q.geo;
      sd_x_q    <= fold ? (XY_W'(0) - sc_side_q.x) : sc_side_q.x;
      sd_y_q    <= fold ? (XY_W'(0) - sc_side_q.y) : sc_side_q.y;
      sd_z_q    <= {{(Z_W-32){t_fold[31]}}, t_fold};
    end
  end

  // rotation
  logic                   cr_vld;
  logic signed [XY_W-1:0] cr_x, cr_y;
  geo_t                   cr_geo;

  swm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sd_vld_q),
    .x_i     ($signed(sd_x_q)),
    .y_i     ($signed(sd_y_q)),
    .z_i     ($signed(sd_z_q)),
    .geo_i   (sd_geo_q),
    .valid_o (cr_vld),
    .x_o     (cr_x),
    .y_o     (cr_y),
    .geo_o   (cr_geo)
  );

  // add center back, round and saturate
  logic [XY_W-1:0]   xr, yr;
  logic [SUMO_W-1:0] ux, uy;
  logic [OUT_W-1:0]  src_x, src_y;

  assign xr = cr_x + XY_W'(32768);
  assign yr = cr_y + XY_W'(32768);
  assign ux = {{(SUMO_W-(XY_W-16)){xr[XY_W-1]}}, xr[XY_W-1:16]}
            + {{(SUMO_W-CX_W){1'b0}}, cr_geo.cx};
  assign uy = {{(SUMO_W-(XY_W-16)){yr[XY_W-1]}}, yr[XY_W-1:16]}
            + {{(SUMO_W-CX_W){1'b0}}, cr_geo.cy};

  function automatic logic [OUT_W-1:0] sat_out(input logic [SUMO_W-1:0] v);
    logic [SUMO_W-OUT_W:0] top;
    top = v[SUMO_W-1:OUT_W-1];
    if (top == '0 || top == '1) begin
      sat_out = v[OUT_W-1:0];
    end else if (v[SUMO_W-1]) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    if (cr_geo.bypass) begin
      src_x = {3'b0, cr_geo.dest_x, 8'b0};
      src_y = {3'b0, cr_geo.dest_y, 8'b0};
    end else begin
      src_x = sat_out(ux);
      src_y = sat_out(uy);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (en) begin
      m_valid_q <= cr_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_data_q <= {2'b0, src_y, src_x};
    end
  end

endmodule

// ----- rtl/core/swm_checker.sv -----
`include "swirl_warp_coordinate_map_macros.svh"

module swm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  // configuration port never waits
  `SWM_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

  // pipeline empties on reset
  `SWM_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

  // input is taken whenever the output side can move
  `SWM_ASSERT(a_ready_free, (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready,
              "input stalled with free output")

  // stalled beat holds
  `SWM_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=>
              (m_axis_tvalid && $stable(m_axis_tdata)), "stalled output beat changed")

endmodule

bind swirl_warp_coordinate_map swm_checker u_swm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
